### rtl/fptg_pkg.sv
package fptg_pkg;

    localparam int MAX_IN_BITS    = 4;
    localparam int MAX_OUT_BITS   = 4;
    localparam int HISTORY_DEPTH  = 3;
    localparam int PROB_FRAC_BITS = 16;

    localparam int ADDR_W     = MAX_IN_BITS + MAX_OUT_BITS;
    localparam int TABLE_SIZE = 1 << ADDR_W;
    localparam int PROB_W     = PROB_FRAC_BITS + 1;
    localparam int SUM_W      = PROB_W + MAX_OUT_BITS + 1;
    localparam int HIST_CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int DIV_CNT_W  = $clog2(PROB_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int RAND_W     = 16;

    localparam logic [PROB_W-1:0] PROB_ONE   = PROB_W'(1 << PROB_FRAC_BITS);
    localparam logic [PROB_W-1:0] PROB_FLOOR =
        PROB_W'(((1 << PROB_FRAC_BITS) + 500) / 1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_COUNT  = 3'd0,
        CFG_OUT_COUNT = 3'd1,
        CFG_POS_DEPTH = 3'd2,
        CFG_NEG_DEPTH = 3'd3,
        CFG_FB_ENABLE = 3'd4,
        CFG_POS_LEVEL = 3'd5,
        CFG_NEG_LEVEL = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_RESTORE = 2'd1,
        REQ_STEP    = 2'd2
    } req_type_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_COPY,
        S_COPY_END,
        S_PH_START,
        S_FB_RD,
        S_FB_WR,
        S_SUM_RD,
        S_SUM_ACC,
        S_NORM_CHK,
        S_NORM_RD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_NEXT_PAIR,
        S_SAMP_RD,
        S_SAMP_CHK,
        S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_LOAD_WR,
        CMD_COPY_RD,
        CMD_HIST_CLR,
        CMD_FB_RD,
        CMD_FB_WR,
        CMD_SUM_RD,
        CMD_SUM_ACC,
        CMD_NORM_RD,
        CMD_DIV_START,
        CMD_NORM_WR,
        CMD_SAMP_RD,
        CMD_SAMP_SUB,
        CMD_SAMP_END,
        CMD_OUT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                op;
        logic [ADDR_W-1:0]      cnt;
        logic [HIST_CNT_W-1:0]  pidx;
        logic                   neg;
    } ctrl_cmd_t;

    typedef struct packed {
        req_type_t              req;
        logic                   pos_go;
        logic                   neg_go;
        logic [HIST_CNT_W-1:0]  fb_count;
        logic                   last_col;
        logic                   sum_zero;
        logic                   div_done;
        logic                   samp_step;
    } dp_status_t;

endpackage

### rtl/fptg_if.sv
interface fptg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  entry_index;
    logic [16:0] entry_value;
    logic [3:0]  in_bits;
    logic        pos_signal;
    logic        neg_signal;
    logic [15:0] rand_select;
    logic [47:0] rand_pos;
    logic [47:0] rand_neg;

    modport source (
        output valid, req_type, entry_index, entry_value, in_bits,
               pos_signal, neg_signal, rand_select, rand_pos, rand_neg,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, entry_value, in_bits,
               pos_signal, neg_signal, rand_select, rand_pos, rand_neg,
        output ready
    );
endinterface

interface fptg_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] out_bits;
    logic [3:0] chosen_row;

    modport source (output valid, out_bits, chosen_row, input ready);
    modport sink (input valid, out_bits, chosen_row, output ready);
endinterface

interface fptg_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fptg_pkg::CFG_IDX_W-1:0]  index;
    logic [fptg_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

### rtl/fptg_div.sv
module fptg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fptg_pkg::PROB_W-1:0] dividend,
    input  logic [fptg_pkg::SUM_W-1:0]  divisor,
    output logic                        done,
    output logic [fptg_pkg::PROB_W-1:0] quotient
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [fptg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [fptg_pkg::SUM_W-1:0]     rem_reg;
    logic [fptg_pkg::SUM_W-1:0]     div_reg;
    logic [fptg_pkg::PROB_W-1:0]    quo_reg;
    logic [fptg_pkg::SUM_W:0]       trial;
    logic                           ge;

    // The dividend never exceeds the divisor, so the first step compares
    // without a shift and yields the integer bit of the quotient.
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            trial = {1'b0, rem_reg};
        end
        else
        begin
            trial = {rem_reg, 1'b0};
        end
        ge = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == fptg_pkg::DIV_CNT_W'(fptg_pkg::PROB_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= fptg_pkg::SUM_W'(dividend);
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= fptg_pkg::SUM_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= fptg_pkg::SUM_W'(trial);
            end
            quo_reg <= {quo_reg[fptg_pkg::PROB_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/fptg_datapath.sv
module fptg_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fptg_pkg::ctrl_cmd_t             cmd,
    output fptg_pkg::dp_status_t            st,
    input  logic [1:0]                      req_type,
    input  logic [7:0]                      entry_index,
    input  logic [16:0]                     entry_value,
    input  logic [3:0]                      in_bits,
    input  logic                            pos_signal,
    input  logic                            neg_signal,
    input  logic [15:0]                     rand_select,
    input  logic [47:0]                     rand_pos,
    input  logic [47:0]                     rand_neg,
    input  logic                            cfg_we,
    input  logic [fptg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fptg_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [3:0]                      out_bits,
    output logic [3:0]                      chosen_row
);

    localparam int AW = fptg_pkg::ADDR_W;
    localparam int PW = fptg_pkg::PROB_W;
    localparam int HW = fptg_pkg::HIST_CNT_W;
    localparam int OB = fptg_pkg::MAX_OUT_BITS;
    localparam int IB = fptg_pkg::MAX_IN_BITS;

    logic [2:0]  in_count_reg;
    logic [2:0]  out_count_reg;
    logic [1:0]  pos_depth_reg;
    logic [1:0]  neg_depth_reg;
    logic        fb_en_reg;
    logic [23:0] pos_lv_reg;
    logic [23:0] neg_lv_reg;

    logic [1:0]  req_q;
    logic [7:0]  idx_q;
    logic [16:0] val_q;
    logic [3:0]  in_bits_q;
    logic        pos_q;
    logic        neg_q;
    logic [47:0] rpos_q;
    logic [47:0] rneg_q;

    logic [PW-1:0] work_mem [fptg_pkg::TABLE_SIZE];
    logic [PW-1:0] orig_mem [fptg_pkg::TABLE_SIZE];
    logic [PW-1:0] work_q;
    logic [PW-1:0] orig_q;
    logic          copy_pend_reg;
    logic [AW-1:0] copy_addr_reg;

    logic [AW-1:0] hist_reg [fptg_pkg::HISTORY_DEPTH];
    logic [HW-1:0] hist_cnt_reg;

    logic [PW-1:0]              mod_reg;
    logic [fptg_pkg::SUM_W-1:0] sum_reg;
    logic [PW-1:0]              samp_r_reg;
    logic [3:0]                 res_bits_reg;
    logic [3:0]                 res_row_reg;
    logic [3:0]                 out_bits_reg;
    logic [3:0]                 out_row_reg;

    logic [2:0]      ib;
    logic [2:0]      ob;
    logic [IB-1:0]   row_mask;
    logic [OB-1:0]   col_last;
    logic [IB-1:0]   samp_row;
    logic [1:0]      depth;
    logic [HW-1:0]   fb_n;
    logic [HW-1:0]   sel;
    logic [AW-1:0]   pair;
    logic [15:0]     r16;
    logic [7:0]      lvl;
    logic [8:0]      lvl9;
    logic [24:0]     prod;
    logic [PW:0]     e_sum;
    logic [PW-1:0]   e_dif;
    logic [PW-1:0]   e_new;
    logic [PW-1:0]   load_val;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [PW-1:0]   wr_data;
    logic            div_done;
    logic [PW-1:0]   div_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= 3'd1;
            out_count_reg <= 3'd1;
            pos_depth_reg <= 2'd0;
            neg_depth_reg <= 2'd0;
            fb_en_reg     <= 1'b1;
            pos_lv_reg    <= '0;
            neg_lv_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (fptg_pkg::cfg_idx_t'(cfg_index))
                fptg_pkg::CFG_IN_COUNT:  in_count_reg  <= cfg_data[2:0];
                fptg_pkg::CFG_OUT_COUNT: out_count_reg <= cfg_data[2:0];
                fptg_pkg::CFG_POS_DEPTH: pos_depth_reg <= cfg_data[1:0];
                fptg_pkg::CFG_NEG_DEPTH: neg_depth_reg <= cfg_data[1:0];
                fptg_pkg::CFG_FB_ENABLE: fb_en_reg     <= cfg_data[0];
                fptg_pkg::CFG_POS_LEVEL: pos_lv_reg    <= cfg_data;
                fptg_pkg::CFG_NEG_LEVEL: neg_lv_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (in_count_reg == 3'd0)
        begin
            ib = 3'd1;
        end
        else if (in_count_reg > 3'(IB))
        begin
            ib = 3'(IB);
        end
        else
        begin
            ib = in_count_reg;
        end
        if (out_count_reg == 3'd0)
        begin
            ob = 3'd1;
        end
        else if (out_count_reg > 3'(OB))
        begin
            ob = 3'(OB);
        end
        else
        begin
            ob = out_count_reg;
        end
        row_mask = IB'(((IB + 1)'(1) << ib) - (IB + 1)'(1));
        col_last = OB'(((OB + 1)'(1) << ob) - (OB + 1)'(1));
        samp_row = in_bits_q & row_mask;
    end

    // Feedback walks the newest pairs of the history, oldest of them first.
    always_comb
    begin
        depth = cmd.neg ? neg_depth_reg : pos_depth_reg;
        if (HW'(depth) < hist_cnt_reg)
        begin
            fb_n = HW'(depth);
        end
        else
        begin
            fb_n = hist_cnt_reg;
        end
        sel  = hist_cnt_reg - fb_n + cmd.pidx;
        pair = hist_reg[fptg_pkg::HISTORY_DEPTH-1];
        r16  = '0;
        lvl  = '0;
        for (int k = 0; k < fptg_pkg::HISTORY_DEPTH; k++)
        begin
            if (sel == HW'(k))
            begin
                pair = hist_reg[k];
            end
            if (cmd.pidx == HW'(k))
            begin
                r16 = cmd.neg ? rneg_q[16*k +: 16] : rpos_q[16*k +: 16];
                lvl = cmd.neg ? neg_lv_reg[8*k +: 8] : pos_lv_reg[8*k +: 8];
            end
        end
        lvl9 = {1'b0, lvl} + 9'd1;
        prod = {9'b0, r16} * {16'b0, lvl9};
    end

    always_comb
    begin
        e_sum = {1'b0, work_q} + {1'b0, mod_reg};
        if (mod_reg >= work_q)
        begin
            e_dif = '0;
        end
        else
        begin
            e_dif = work_q - mod_reg;
        end
        if (e_dif < fptg_pkg::PROB_FLOOR)
        begin
            e_dif = fptg_pkg::PROB_FLOOR;
        end
        e_new = cmd.neg ? e_dif : e_sum[PW-1:0];
        if (val_q > fptg_pkg::PROB_ONE)
        begin
            load_val = fptg_pkg::PROB_ONE;
        end
        else
        begin
            load_val = val_q;
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = pair;
        case (cmd.op)
            fptg_pkg::CMD_FB_RD:
            begin
                rd_en = 1'b1;
            end
            fptg_pkg::CMD_SUM_RD, fptg_pkg::CMD_NORM_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = {pair[AW-1:OB], cmd.cnt[OB-1:0]};
            end
            fptg_pkg::CMD_SAMP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = {samp_row, cmd.cnt[OB-1:0]};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pair;
        wr_data = e_new;
        if (copy_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = orig_q;
        end
        else
        begin
            case (cmd.op)
                fptg_pkg::CMD_LOAD_WR:
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_q;
                    wr_data = load_val;
                end
                fptg_pkg::CMD_FB_WR:
                begin
                    wr_en = 1'b1;
                end
                fptg_pkg::CMD_NORM_WR:
                begin
                    wr_en   = 1'b1;
                    wr_addr = {pair[AW-1:OB], cmd.cnt[OB-1:0]};
                    wr_data = div_quo;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            work_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            work_q <= work_mem[rd_addr];
        end
        if (cmd.op == fptg_pkg::CMD_LOAD_WR)
        begin
            orig_mem[idx_q] <= load_val;
        end
        if (cmd.op == fptg_pkg::CMD_COPY_RD)
        begin
            orig_q <= orig_mem[cmd.cnt];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_pend_reg <= 1'b0;
        end
        else
        begin
            copy_pend_reg <= (cmd.op == fptg_pkg::CMD_COPY_RD);
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= cmd.cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_cnt_reg <= '0;
            for (int k = 0; k < fptg_pkg::HISTORY_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (cmd.op == fptg_pkg::CMD_HIST_CLR)
        begin
            hist_cnt_reg <= '0;
            for (int k = 0; k < fptg_pkg::HISTORY_DEPTH; k++)
            begin
                hist_reg[k] <= '0;
            end
        end
        else if (cmd.op == fptg_pkg::CMD_SAMP_END && fb_en_reg)
        begin
            if (hist_cnt_reg < HW'(fptg_pkg::HISTORY_DEPTH))
            begin
                for (int k = 0; k < fptg_pkg::HISTORY_DEPTH; k++)
                begin
                    if (hist_cnt_reg == HW'(k))
                    begin
                        hist_reg[k] <= {samp_row, cmd.cnt[OB-1:0]};
                    end
                end
                hist_cnt_reg <= hist_cnt_reg + 1'b1;
            end
            else
            begin
                for (int k = 0; k < fptg_pkg::HISTORY_DEPTH - 1; k++)
                begin
                    hist_reg[k] <= hist_reg[k+1];
                end
                hist_reg[fptg_pkg::HISTORY_DEPTH-1] <= {samp_row, cmd.cnt[OB-1:0]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            fptg_pkg::CMD_LATCH:
            begin
                req_q        <= req_type;
                idx_q        <= entry_index;
                val_q        <= entry_value;
                in_bits_q    <= in_bits;
                pos_q        <= pos_signal;
                neg_q        <= neg_signal;
                rpos_q       <= rand_pos;
                rneg_q       <= rand_neg;
                samp_r_reg   <= PW'(rand_select);
                res_bits_reg <= '0;
                res_row_reg  <= '0;
            end
            fptg_pkg::CMD_FB_RD:
            begin
                mod_reg <= prod[24:8];
            end
            fptg_pkg::CMD_FB_WR:
            begin
                sum_reg <= '0;
            end
            fptg_pkg::CMD_SUM_ACC:
            begin
                sum_reg <= sum_reg + fptg_pkg::SUM_W'(work_q);
            end
            fptg_pkg::CMD_SAMP_SUB:
            begin
                samp_r_reg <= samp_r_reg - work_q;
            end
            fptg_pkg::CMD_SAMP_END:
            begin
                res_bits_reg <= 4'(cmd.cnt[OB-1:0]);
                res_row_reg  <= 4'(samp_row);
            end
            fptg_pkg::CMD_OUT:
            begin
                out_bits_reg <= res_bits_reg;
                out_row_reg  <= res_row_reg;
            end
            default: ;
        endcase
    end

    fptg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == fptg_pkg::CMD_DIV_START),
        .dividend (work_q),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        st.req       = fptg_pkg::req_type_t'(req_q);
        st.pos_go    = fb_en_reg & pos_q;
        st.neg_go    = fb_en_reg & neg_q;
        st.fb_count  = fb_n;
        st.last_col  = (cmd.cnt[OB-1:0] == col_last);
        st.sum_zero  = (sum_reg == '0);
        st.div_done  = div_done;
        st.samp_step = (cmd.cnt[OB-1:0] != col_last) && (samp_r_reg > work_q);
    end

    assign out_bits   = out_bits_reg;
    assign chosen_row = out_row_reg;

endmodule

### rtl/fptg_ctrl.sv
module fptg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  fptg_pkg::dp_status_t st,
    output fptg_pkg::ctrl_cmd_t  cmd
);

    localparam int AW = fptg_pkg::ADDR_W;
    localparam int HW = fptg_pkg::HIST_CNT_W;

    fptg_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [HW-1:0]    pidx_reg, pidx_next;
    logic             phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;
    logic             go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fptg_pkg::S_IDLE;
            cnt_reg       <= '0;
            pidx_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pidx_reg      <= pidx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pidx_next      = pidx_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = fptg_pkg::CMD_NONE;
        cmd.cnt        = cnt_reg;
        cmd.pidx       = pidx_reg;
        cmd.neg        = phase_reg;
        go             = phase_reg ? st.neg_go : st.pos_go;
        case (state_reg)
            fptg_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = fptg_pkg::CMD_LATCH;
                    state_next = fptg_pkg::S_DISPATCH;
                end
            end
            fptg_pkg::S_DISPATCH:
            begin
                cnt_next   = '0;
                pidx_next  = '0;
                phase_next = 1'b0;
                case (st.req)
                    fptg_pkg::REQ_LOAD:    state_next = fptg_pkg::S_LOAD;
                    fptg_pkg::REQ_RESTORE: state_next = fptg_pkg::S_COPY;
                    fptg_pkg::REQ_STEP:    state_next = fptg_pkg::S_PH_START;
                    default:               state_next = fptg_pkg::S_FINISH;
                endcase
            end
            fptg_pkg::S_LOAD:
            begin
                cmd.op     = fptg_pkg::CMD_LOAD_WR;
                state_next = fptg_pkg::S_FINISH;
            end
            fptg_pkg::S_COPY:
            begin
                cmd.op   = fptg_pkg::CMD_COPY_RD;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(fptg_pkg::TABLE_SIZE - 1))
                begin
                    state_next = fptg_pkg::S_COPY_END;
                end
            end
            fptg_pkg::S_COPY_END:
            begin
                cmd.op     = fptg_pkg::CMD_HIST_CLR;
                state_next = fptg_pkg::S_FINISH;
            end
            fptg_pkg::S_PH_START:
            begin
                if (go && (pidx_reg < st.fb_count))
                begin
                    state_next = fptg_pkg::S_FB_RD;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    pidx_next  = '0;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = fptg_pkg::S_SAMP_RD;
                end
            end
            fptg_pkg::S_FB_RD:
            begin
                cmd.op     = fptg_pkg::CMD_FB_RD;
                state_next = fptg_pkg::S_FB_WR;
            end
            fptg_pkg::S_FB_WR:
            begin
                cmd.op     = fptg_pkg::CMD_FB_WR;
                cnt_next   = '0;
                state_next = fptg_pkg::S_SUM_RD;
            end
            fptg_pkg::S_SUM_RD:
            begin
                cmd.op     = fptg_pkg::CMD_SUM_RD;
                state_next = fptg_pkg::S_SUM_ACC;
            end
            fptg_pkg::S_SUM_ACC:
            begin
                cmd.op = fptg_pkg::CMD_SUM_ACC;
                if (st.last_col)
                begin
                    cnt_next   = '0;
                    state_next = fptg_pkg::S_NORM_CHK;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = fptg_pkg::S_SUM_RD;
                end
            end
            fptg_pkg::S_NORM_CHK:
            begin
                state_next = st.sum_zero ? fptg_pkg::S_NEXT_PAIR : fptg_pkg::S_NORM_RD;
            end
            fptg_pkg::S_NORM_RD:
            begin
                cmd.op     = fptg_pkg::CMD_NORM_RD;
                state_next = fptg_pkg::S_DIV_GO;
            end
            fptg_pkg::S_DIV_GO:
            begin
                cmd.op     = fptg_pkg::CMD_DIV_START;
                state_next = fptg_pkg::S_DIV_WAIT;
            end
            fptg_pkg::S_DIV_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.op = fptg_pkg::CMD_NORM_WR;
                    if (st.last_col)
                    begin
                        state_next = fptg_pkg::S_NEXT_PAIR;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = fptg_pkg::S_NORM_RD;
                    end
                end
            end
            fptg_pkg::S_NEXT_PAIR:
            begin
                pidx_next  = pidx_reg + 1'b1;
                state_next = fptg_pkg::S_PH_START;
            end
            fptg_pkg::S_SAMP_RD:
            begin
                cmd.op     = fptg_pkg::CMD_SAMP_RD;
                state_next = fptg_pkg::S_SAMP_CHK;
            end
            fptg_pkg::S_SAMP_CHK:
            begin
                if (st.samp_step)
                begin
                    cmd.op     = fptg_pkg::CMD_SAMP_SUB;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = fptg_pkg::S_SAMP_RD;
                end
                else
                begin
                    cmd.op     = fptg_pkg::CMD_SAMP_END;
                    state_next = fptg_pkg::S_FINISH;
                end
            end
            fptg_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = fptg_pkg::CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = fptg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fptg_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == fptg_pkg::S_DISPATCH))
        else $error("accepted transfer did not reach dispatch");

    a_pair_in_history: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fptg_pkg::S_FB_RD) |-> (pidx_reg < st.fb_count))
        else $error("feedback pair index beyond history");

    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == fptg_pkg::CMD_OUT) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    a_div_leaves_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fptg_pkg::S_DIV_WAIT && st.div_done)
            |=> (state_reg != fptg_pkg::S_DIV_WAIT))
        else $error("divider result not consumed");

endmodule

### rtl/feedback_probabilistic_table_gate.sv
// Stochastic table gate with reinforcement.
// The req channel carries one request per transfer: a table load, a restore of
// the loaded table, or a step that samples an output column from the row named
// by in_bits. Every request yields exactly one transfer on the res channel;
// load and restore return zeros. The cfg channel writes a register by index and
// is always ready; write it only while no request is in flight.
// One request is processed at a time. A load writes one entry. A restore
// copies the original table into the working table, one entry per cycle. A
// step, for each feedback pair, updates that pair's entry, sums its row and
// normalizes each of the C entries of that row with the serial divider, C
// being the column count; the sampling walk then visits columns until it
// picks one. A step handles at most six pairs, over at most 16 columns.
// Reset clears the configuration to its defaults and empties the history; the
// table memories hold no defined contents until loaded.
// The result sits in an output register; a new request is accepted while it
// waits, and processing stalls only at completion until that slot frees up.
module feedback_probabilistic_table_gate (
    input  logic       clk,
    input  logic       rst_n,
    fptg_req_if.sink   req,
    fptg_res_if.source res,
    fptg_cfg_if.sink   cfg
);

    fptg_pkg::ctrl_cmd_t  cmd;
    fptg_pkg::dp_status_t st;

    assign cfg.ready = 1'b1;

    fptg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .st        (st),
        .cmd       (cmd)
    );

    fptg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .req_type    (req.req_type),
        .entry_index (req.entry_index),
        .entry_value (req.entry_value),
        .in_bits     (req.in_bits),
        .pos_signal  (req.pos_signal),
        .neg_signal  (req.neg_signal),
        .rand_select (req.rand_select),
        .rand_pos    (req.rand_pos),
        .rand_neg    (req.rand_neg),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.wdata),
        .out_bits    (res.out_bits),
        .chosen_row  (res.chosen_row)
    );

endmodule
